FILE: rtl/mi4_pkg.sv
// mi4_pkg: shared constants and index helpers for the 4x4 matrix inverse unit
`timescale 1ns / 1ps
`default_nettype none

package mi4_pkg;

    // index of the last of the six terms in a 3x3 determinant expansion
    localparam logic [2:0] TERM_LAST = 3'd5;

    // column permutation of one 3x3 expansion term, packed as {c0, c1, c2}
    function automatic logic [5:0] perm_cols(input logic [2:0] term);
        logic [5:0] p;
        case (term)
            3'd0:    p = {2'd0, 2'd1, 2'd2};
            3'd1:    p = {2'd0, 2'd2, 2'd1};
            3'd2:    p = {2'd1, 2'd0, 2'd2};
            3'd3:    p = {2'd1, 2'd2, 2'd0};
            3'd4:    p = {2'd2, 2'd0, 2'd1};
            3'd5:    p = {2'd2, 2'd1, 2'd0};
            default: p = {2'd0, 2'd1, 2'd2};
        endcase
        return p;
    endfunction

    // odd permutations carry a minus sign
    function automatic logic perm_neg(input logic [2:0] term);
        return (term == 3'd1) || (term == 3'd2) || (term == 3'd5);
    endfunction

    // map a submatrix row or column to the full matrix, skipping the excluded one
    function automatic logic [1:0] skip_index(input logic [1:0] sub, input logic [1:0] excl);
        return (sub >= excl) ? sub + 2'd1 : sub;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/matrix_inverse_4x4_unit.sv
// matrix_inverse_4x4_unit: exact fixed-point 4x4 matrix inverse by the adjugate method
`timescale 1ns / 1ps
`default_nettype none

// usage
//   input channel (in_valid / in_ready): each transfer writes elem_value into the
//   16-entry matrix store at row-major elem_index. a store-only transfer leaves
//   the block ready for the next transfer. a transfer with compute_now set
//   stores its element and then inverts the stored matrix; in_ready stays low
//   until the sixteenth result has been moved into the output register
//   output channel (out_valid / out_ready): sixteen results, out_index 0 to 15 in
//   order, last_of_run on the final one. singular flags a zero determinant (all
//   values zero); saturated flags a quotient clamped to the signed range
//   datapath: one shared wide adder does the multiply and divide arithmetic. each
//   product is bit-serial, one adder step per multiplier bit. the sequencer
//   builds the sixteen 3x3 minors from six terms each, then the determinant from
//   four products along the first row, then one restoring division per result
//   a stalled receiver holds the result register and the sequencer waits on it
//   reset clears the sequencer and the output valid; the matrix store is not
//   cleared and entries must be written before a compute
module matrix_inverse_4x4_unit #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [3:0]            elem_index,
    input  wire logic [DATA_WIDTH-1:0] elem_value,
    input  wire logic                  compute_now,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [3:0]                 out_index,
    output logic [DATA_WIDTH-1:0]      out_value,
    output logic                       singular,
    output logic                       saturated,
    output logic                       last_of_run
);

    localparam int W     = DATA_WIDTH;
    localparam int CW    = 3 * W + 2;          // cofactor width
    localparam int DW    = 4 * W + 2;          // determinant width
    localparam int AW    = DW + 2;             // shared adder width
    localparam int NW    = CW + 2 * FRAC_BITS; // scaled numerator width
    localparam int CNT_W = $clog2(NW);

    // sequencer states
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_LA1    = 4'd1;  // load first multiplicand
    localparam logic [3:0] S_LA2    = 4'd2;  // load first multiplier
    localparam logic [3:0] S_MA     = 4'd3;  // pair product
    localparam logic [3:0] S_LB     = 4'd4;  // load third factor
    localparam logic [3:0] S_MB     = 4'd5;  // triple product into minor
    localparam logic [3:0] S_CSTORE = 4'd6;  // store cofactor
    localparam logic [3:0] S_DLOAD  = 4'd7;  // load determinant term
    localparam logic [3:0] S_DMUL   = 4'd8;  // determinant product
    localparam logic [3:0] S_DCHK   = 4'd9;  // determinant sign and magnitude
    localparam logic [3:0] S_VLOAD  = 4'd10; // load numerator
    localparam logic [3:0] S_VDIV   = 4'd11; // restoring division
    localparam logic [3:0] S_VEMIT  = 4'd12; // hand result to output register

    logic [3:0]       state_reg, state_next;
    logic [3:0]       k_reg, k_next;
    logic [2:0]       term_reg, term_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DW-1:0]    mcand_reg, mcand_next;
    logic [W-1:0]     mplier_reg, mplier_next;
    logic [2*W-1:0]   prod_reg, prod_next;
    logic [DW-1:0]    acc_reg, acc_next;
    logic [DW-1:0]    dmag_reg, dmag_next;
    logic             dneg_reg, dneg_next;
    logic             dzero_reg, dzero_next;
    logic [NW-1:0]    nsh_reg, nsh_next;
    logic             nneg_reg, nneg_next;
    logic [DW-1:0]    rem_reg, rem_next;
    logic [W-1:0]     quo_reg, quo_next;
    logic             big_reg, big_next;

    logic             out_valid_reg;
    logic [3:0]       out_index_reg;
    logic [W-1:0]     out_value_reg;
    logic             singular_reg, saturated_reg, last_reg;

    logic [W-1:0]     store_mem [16];
    logic [CW-1:0]    cof_mem [16];

    // element and cofactor read ports
    logic [5:0]       pcols;
    logic [1:0]       sub_row, sub_col;
    logic [3:0]       rd_addr;
    logic [W-1:0]     elem;
    logic [3:0]       cof_addr;
    logic [CW-1:0]    cof;

    // shared adder
    logic [AW-1:0]    opx, opy, sum;
    logic             inv;
    logic             last_bit, term_neg, ge;

    logic             in_xfer, out_xfer, emit_go;
    logic             qneg, over;
    logic [W-1:0]     lim, mag, val;
    logic [CW-1:0]    cof_abs;
    logic [DW-1:0]    det_abs;
    logic             cof_we;

    assign in_xfer  = in_valid && in_ready;
    assign out_xfer = out_valid_reg && out_ready;
    assign in_ready = (state_reg == S_IDLE);
    assign emit_go  = (state_reg == S_VEMIT) && (!out_valid_reg || out_ready);

    assign pcols    = mi4_pkg::perm_cols(term_reg);
    assign last_bit = (cnt_reg == CNT_W'(W - 1));
    assign term_neg = mi4_pkg::perm_neg(term_reg) ^ k_reg[2] ^ k_reg[0];

    // which submatrix element the current step needs
    always_comb
    begin
        sub_row = 2'd0;
        sub_col = pcols[5:4];
        case (state_reg)
            S_LA1:
            begin
                sub_row = 2'd1;
                sub_col = pcols[3:2];
            end
            S_LA2:
            begin
                sub_row = 2'd2;
                sub_col = pcols[1:0];
            end
            default:
            begin
                sub_row = 2'd0;
                sub_col = pcols[5:4];
            end
        endcase
        if (state_reg == S_DLOAD)
            rd_addr = {2'd0, k_reg[1:0]};
        else
            rd_addr = {mi4_pkg::skip_index(sub_row, k_reg[3:2]),
                       mi4_pkg::skip_index(sub_col, k_reg[1:0])};
    end

    assign elem     = store_mem[rd_addr];
    // transposed cofactor for the division, straight for the determinant
    assign cof_addr = (state_reg == S_VLOAD) ? {k_reg[1:0], k_reg[3:2]} : k_reg;
    assign cof      = cof_mem[cof_addr];
    assign cof_abs  = cof[CW-1] ? CW'(-cof) : cof;
    assign det_abs  = acc_reg[DW-1] ? DW'(-acc_reg) : acc_reg;

    // operand selection for the shared adder
    always_comb
    begin
        case (state_reg)
            S_MA:
            begin
                opx = {{(AW-2*W){prod_reg[2*W-1]}}, prod_reg};
                opy = {{(AW-DW){mcand_reg[DW-1]}}, mcand_reg};
                inv = last_bit;
            end
            S_MB:
            begin
                opx = {{(AW-DW){acc_reg[DW-1]}}, acc_reg};
                opy = {{(AW-DW){mcand_reg[DW-1]}}, mcand_reg};
                inv = last_bit ^ term_neg;
            end
            S_DMUL:
            begin
                opx = {{(AW-DW){acc_reg[DW-1]}}, acc_reg};
                opy = {{(AW-DW){mcand_reg[DW-1]}}, mcand_reg};
                inv = last_bit;
            end
            S_VDIV:
            begin
                opx = {1'b0, rem_reg, nsh_reg[NW-1]};
                opy = {2'b00, dmag_reg};
                inv = 1'b1;
            end
            default:
            begin
                opx = '0;
                opy = '0;
                inv = 1'b0;
            end
        endcase
        sum = opx + (opy ^ {AW{inv}}) + AW'(inv);
    end

    assign ge = !sum[AW-1];

    // result formatting: sign, clamp to range
    always_comb
    begin
        qneg = nneg_reg ^ dneg_reg;
        lim  = qneg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        over = big_reg || (qneg ? (quo_reg[W-1] && (|quo_reg[W-2:0])) : quo_reg[W-1]);
        mag  = over ? lim : quo_reg;
        val  = qneg ? W'(-mag) : mag;
    end

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        k_next      = k_reg;
        term_next   = term_reg;
        cnt_next    = cnt_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        prod_next   = prod_reg;
        acc_next    = acc_reg;
        dmag_next   = dmag_reg;
        dneg_next   = dneg_reg;
        dzero_next  = dzero_reg;
        nsh_next    = nsh_reg;
        nneg_next   = nneg_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        big_next    = big_reg;
        cof_we      = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer && compute_now)
                begin
                    k_next     = 4'd0;
                    term_next  = 3'd0;
                    acc_next   = '0;
                    state_next = S_LA1;
                end
            end
            S_LA1:
            begin
                mcand_next = {{(DW-W){elem[W-1]}}, elem};
                state_next = S_LA2;
            end
            S_LA2:
            begin
                mplier_next = elem;
                prod_next   = '0;
                cnt_next    = '0;
                state_next  = S_MA;
            end
            S_MA:
            begin
                if (mplier_reg[0])
                    prod_next = sum[2*W-1:0];
                mcand_next  = {mcand_reg[DW-2:0], 1'b0};
                mplier_next = {1'b0, mplier_reg[W-1:1]};
                cnt_next    = cnt_reg + 1'b1;
                if (last_bit)
                    state_next = S_LB;
            end
            S_LB:
            begin
                mcand_next  = {{(DW-2*W){prod_reg[2*W-1]}}, prod_reg};
                mplier_next = elem;
                cnt_next    = '0;
                state_next  = S_MB;
            end
            S_MB:
            begin
                if (mplier_reg[0])
                    acc_next = sum[DW-1:0];
                mcand_next  = {mcand_reg[DW-2:0], 1'b0};
                mplier_next = {1'b0, mplier_reg[W-1:1]};
                cnt_next    = cnt_reg + 1'b1;
                if (last_bit)
                begin
                    if (term_reg == mi4_pkg::TERM_LAST)
                        state_next = S_CSTORE;
                    else
                    begin
                        term_next  = term_reg + 3'd1;
                        state_next = S_LA1;
                    end
                end
            end
            S_CSTORE:
            begin
                cof_we    = 1'b1;
                acc_next  = '0;
                term_next = 3'd0;
                k_next    = k_reg + 4'd1;
                if (k_reg == 4'd15)
                    state_next = S_DLOAD;
                else
                    state_next = S_LA1;
            end
            S_DLOAD:
            begin
                mplier_next = elem;
                mcand_next  = {{(DW-CW){cof[CW-1]}}, cof};
                cnt_next    = '0;
                state_next  = S_DMUL;
            end
            S_DMUL:
            begin
                if (mplier_reg[0])
                    acc_next = sum[DW-1:0];
                mcand_next  = {mcand_reg[DW-2:0], 1'b0};
                mplier_next = {1'b0, mplier_reg[W-1:1]};
                cnt_next    = cnt_reg + 1'b1;
                if (last_bit)
                begin
                    if (k_reg == 4'd3)
                    begin
                        k_next     = 4'd0;
                        state_next = S_DCHK;
                    end
                    else
                    begin
                        k_next     = k_reg + 4'd1;
                        state_next = S_DLOAD;
                    end
                end
            end
            S_DCHK:
            begin
                dneg_next  = acc_reg[DW-1];
                dmag_next  = det_abs;
                dzero_next = (acc_reg == '0);
                state_next = S_VLOAD;
            end
            S_VLOAD:
            begin
                quo_next = '0;
                big_next = 1'b0;
                rem_next = '0;
                cnt_next = '0;
                if (dzero_reg)
                begin
                    nneg_next  = 1'b0;
                    state_next = S_VEMIT;
                end
                else
                begin
                    nneg_next  = cof[CW-1];
                    nsh_next   = {cof_abs, {(2*FRAC_BITS){1'b0}}};
                    state_next = S_VDIV;
                end
            end
            S_VDIV:
            begin
                if (ge)
                    rem_next = sum[DW-1:0];
                else
                    rem_next = {rem_reg[DW-2:0], nsh_reg[NW-1]};
                nsh_next = {nsh_reg[NW-2:0], 1'b0};
                quo_next = {quo_reg[W-2:0], ge};
                big_next = big_reg || quo_reg[W-1];
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(NW - 1))
                    state_next = S_VEMIT;
            end
            S_VEMIT:
            begin
                if (emit_go)
                begin
                    k_next = k_reg + 4'd1;
                    if (k_reg == 4'd15)
                        state_next = S_IDLE;
                    else
                        state_next = S_VLOAD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            k_reg         <= 4'd0;
            term_reg      <= 3'd0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            term_reg  <= term_next;
            cnt_reg   <= cnt_next;
            if (emit_go)
                out_valid_reg <= 1'b1;
            else if (out_xfer)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        prod_reg   <= prod_next;
        acc_reg    <= acc_next;
        dmag_reg   <= dmag_next;
        dneg_reg   <= dneg_next;
        dzero_reg  <= dzero_next;
        nsh_reg    <= nsh_next;
        nneg_reg   <= nneg_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        big_reg    <= big_next;
        if (emit_go)
        begin
            out_index_reg <= k_reg;
            out_value_reg <= dzero_reg ? '0 : val;
            singular_reg  <= dzero_reg;
            saturated_reg <= !dzero_reg && over;
            last_reg      <= (k_reg == 4'd15);
        end
    end

    // matrix and cofactor stores
    always_ff @(posedge clk)
    begin
        if (in_xfer)
            store_mem[elem_index] <= elem_value;
        if (cof_we)
            cof_mem[k_reg] <= acc_reg[CW-1:0];
    end

    assign out_valid   = out_valid_reg;
    assign out_index   = out_index_reg;
    assign out_value   = out_value_reg;
    assign singular    = singular_reg;
    assign saturated   = saturated_reg;
    assign last_of_run = last_reg;

    // a compute transfer always takes the block busy
    a_busy_after_compute: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && compute_now) |=> !in_ready)
        else $error("ready after compute transfer");

    // last flag marks exactly the final index
    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last_of_run == (out_index == 4'd15)))
        else $error("last_of_run mismatch");

    // singular results are zero and never clamped
    a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && singular) |-> (!saturated && (out_value == '0)))
        else $error("singular result not zero");

    // no result is produced while the block is ready for input
    a_no_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> (state_reg != S_VEMIT) && (state_reg != S_VDIV))
        else $error("division active while idle");

endmodule

`default_nettype wire
